// File: rtl/hamfd_pkg.sv
// ----------------------------------------------------------------------------
// hamfd_pkg: shared types and constants for the hilbert am/fm demodulator
// tap count, cordic arctangent table, sequencer states
// ----------------------------------------------------------------------------
package hamfd_pkg;

  localparam int Taps = 15;
  localparam int TapMid = (Taps - 1) / 2;
  localparam int SampleBits = 16;
  localparam int CordicSteps = 16;
  localparam int PtrW = $clog2(Taps);
  localparam int RateW = 18;
  localparam int EnvW = 16;
  localparam int FreqW = 22;
  localparam int AccW = 40;
  localparam int CordW = 44;
  localparam int StepW = $clog2(CordicSteps);
  localparam logic [RateW-1:0] RateReset = 18'd44100;
  localparam logic [16:0] InvGain = 17'd39797;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_ROUND,
    ST_CORDIC,
    ST_ENV,
    ST_FREQ,
    ST_OUT
  } state_t;

  // tap i applies to the sample delayed by i, m = i - (Taps-1)/2
  // odd m gives 2/(pi m) in q16, even m gives zero
  function automatic logic signed [17:0] tap_coef(input logic [PtrW-1:0] i);
    logic signed [17:0] r;
    case (i)
      4'd0:    r = -18'sd5960;
      4'd2:    r = -18'sd8344;
      4'd4:    r = -18'sd13907;
      4'd6:    r = -18'sd41722;
      4'd8:    r = 18'sd41722;
      4'd10:   r = 18'sd13907;
      4'd12:   r = 18'sd8344;
      4'd14:   r = 18'sd5960;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] atan_turn(input logic [StepW-1:0] i);
    logic [31:0] r;
    case (i)
      4'd0:  r = 32'h20000000;
      4'd1:  r = 32'h12E4051E;
      4'd2:  r = 32'h09FB385B;
      4'd3:  r = 32'h051111D4;
      4'd4:  r = 32'h028B0D43;
      4'd5:  r = 32'h0145D7E1;
      4'd6:  r = 32'h00A2F61E;
      4'd7:  r = 32'h00517C55;
      4'd8:  r = 32'h0028BE53;
      4'd9:  r = 32'h00145F2F;
      4'd10: r = 32'h000A2F98;
      4'd11: r = 32'h000517CC;
      4'd12: r = 32'h00028BE6;
      4'd13: r = 32'h000145F3;
      4'd14: r = 32'h0000A2FA;
      4'd15: r = 32'h0000517D;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/hilbert_am_fm_demodulator.sv
// ----------------------------------------------------------------------------
// hilbert_am_fm_demodulator: envelope and instantaneous frequency of audio
// hilbert fir quadrature, cordic vectoring, phase difference scaled by rate
// ----------------------------------------------------------------------------
// One sample goes in, one word comes out with the envelope (unsigned q16.0,
// in input sample lsbs) and frequency (hz, 4 fraction bits). The result word
// is offered after the sample is accepted and has passed through the fir,
// which runs one tap a cycle through a single 16x18 multiplier, a rounding
// step, the cordic micro-rotation unit, and the envelope and frequency
// multiplies, which load the output register. The block takes no new sample
// until the result has been taken and the sequencer is idle again.
// sample_rate is written via cfg_we/cfg_wdata.
module hilbert_am_fm_demodulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hamfd_pkg::SampleBits-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hamfd_pkg::EnvW-1:0]           out_envelope,
  output logic signed [hamfd_pkg::FreqW-1:0]   out_frequency,
  input  logic                                 cfg_we,
  input  logic [hamfd_pkg::RateW-1:0]          cfg_wdata
);
  import hamfd_pkg::*;

  state_t state_r, state_nxt;
  logic signed [SampleBits-1:0] dline_r [Taps];
  logic [PtrW-1:0] wptr_r;
  logic [PtrW-1:0] tap_r;
  logic [StepW-1:0] step_r;
  logic [15:0] last_phase_r;
  logic [RateW-1:0] rate_r;
  logic signed [AccW-1:0] acc_r;
  logic signed [CordW-1:0] x_r, y_r;
  logic [31:0] z_r;
  logic zero_r;
  logic [EnvW-1:0] env_r;
  logic signed [FreqW-1:0] freq_r;
  logic [PtrW-1:0] cur_ptr_r;

  // fir tap select
  logic [PtrW:0] rd_sum;
  logic [PtrW-1:0] rd_idx;
  logic signed [17:0] coef;
  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] im_full;
  logic [PtrW:0] c_sum;
  logic [PtrW-1:0] c_idx;
  logic signed [SampleBits-1:0] re_val;
  logic signed [CordW-1:0] x0, y0, dx, dy;
  logic [48:0] env_prod;
  logic [48:0] env_sh;
  logic [15:0] phase;
  logic signed [16:0] dphase;
  logic signed [16+RateW+1:0] fprod;
  logic fsm_fir_done, fsm_cordic_done;

  always_comb begin
    rd_sum = {1'b0, cur_ptr_r} + (PtrW+1)'(Taps) - {1'b0, tap_r};
    rd_idx = (rd_sum >= (PtrW+1)'(Taps)) ? PtrW'(rd_sum - (PtrW+1)'(Taps)) : rd_sum[PtrW-1:0];
    coef = tap_coef(tap_r);
    prod = AccW'(coef) * AccW'(dline_r[rd_idx]);
    im_full = (acc_r + AccW'(32768)) >>> 16;
    c_sum = {1'b0, cur_ptr_r} + (PtrW+1)'(Taps - TapMid);
    c_idx = (c_sum >= (PtrW+1)'(Taps)) ? PtrW'(c_sum - (PtrW+1)'(Taps)) : c_sum[PtrW-1:0];
    re_val = dline_r[c_idx];
    x0 = CordW'(re_val) <<< 8;
    y0 = CordW'(im_full) <<< 8;
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    // x stays non-negative and well inside 32 bits after the rotations
    env_prod = 49'(x_r[31:0]) * 49'(InvGain);
    env_sh = (env_prod + 49'(1 << 23)) >> 24;
    phase = zero_r ? 16'd0 : 16'((z_r + 32'h8000) >> 16);
    dphase = 17'($signed(phase - last_phase_r));
    fprod = (16+RateW+2)'(dphase) * (16+RateW+2)'($signed({1'b0, rate_r}));
    fsm_fir_done = (tap_r == PtrW'(Taps - 1));
    fsm_cordic_done = (step_r == StepW'(CordicSteps - 1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_FIR;
      ST_FIR:    if (fsm_fir_done) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_CORDIC;
      ST_CORDIC: if (fsm_cordic_done) state_nxt = ST_ENV;
      ST_ENV:    state_nxt = ST_FREQ;
      ST_FREQ:   state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
  end

  assign out_envelope = env_r;
  assign out_frequency = freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wptr_r <= '0;
      last_phase_r <= '0;
      rate_r <= RateReset;
      for (int k = 0; k < Taps; k++) dline_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) rate_r <= cfg_wdata;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dline_r[wptr_r] <= in_sample;
            cur_ptr_r <= wptr_r;
            wptr_r <= (wptr_r == PtrW'(Taps - 1)) ? '0 : wptr_r + 1'b1;
            tap_r <= '0;
            acc_r <= '0;
          end
        end
        ST_FIR: begin
          acc_r <= acc_r + prod;
          tap_r <= tap_r + 1'b1;
        end
        ST_ROUND: begin
          zero_r <= (re_val == '0) && (im_full == '0);
          step_r <= '0;
          if (re_val < 0) begin
            x_r <= -x0;
            y_r <= -y0;
            z_r <= 32'h80000000;
          end else begin
            x_r <= x0;
            y_r <= y0;
            z_r <= '0;
          end
        end
        ST_CORDIC: begin
          if (y_r >= 0) begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atan_turn(step_r);
          end else begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atan_turn(step_r);
          end
          step_r <= step_r + 1'b1;
        end
        ST_ENV: begin
          if (env_sh > 49'(65535)) env_r <= '1;
          else env_r <= EnvW'(env_sh);
        end
        ST_FREQ: begin
          freq_r <= FreqW'((fprod + (16+RateW+2)'(2048)) >>> 12);
          last_phase_r <= phase;
        end
        default: ;
      endcase
    end
  end

endmodule
